### rtl/vmblk_pkg.sv
// vmblk_pkg: shared types, register offsets and constants for the virtio-mmio
// block device register file. Depends on nothing; every rtl file uses it.

package vmblk_pkg;

    // Sizing of the device
    localparam int unsigned QUEUE_LIMIT     = 256;
    localparam int unsigned SECTOR_BYTES    = 512;
    localparam int unsigned CFG_SPACE_BYTES = 64;

    // Identity words and fixed values
    localparam logic [31:0] MAGIC_WORD   = 32'h7472_6976;
    localparam logic [31:0] VERSION_WORD = 32'd2;
    localparam logic [31:0] BLOCK_ID     = 32'd2;
    localparam logic [31:0] VENDOR_WORD  = 32'h4156_4d31;
    // VERSION_1 (bit 32) and BLK_SIZE (bit 6)
    localparam logic [63:0] FEAT_ALL     = 64'h0000_0001_0000_0040;
    localparam logic [3:0]  WORD_BYTES   = 4'd4;

    typedef logic [8:0] offset_t;

    // Device config window
    localparam offset_t     CFG_BASE   = 9'h100;
    localparam int unsigned BLKSIZE_AT = 20;

    // Register offsets
    localparam offset_t OFF_MAGIC         = 9'h000;
    localparam offset_t OFF_VERSION       = 9'h004;
    localparam offset_t OFF_DEVICE_ID     = 9'h008;
    localparam offset_t OFF_VENDOR_ID     = 9'h00c;
    localparam offset_t OFF_DEV_FEAT      = 9'h010;
    localparam offset_t OFF_DEV_FEAT_SEL  = 9'h014;
    localparam offset_t OFF_DRV_FEAT      = 9'h020;
    localparam offset_t OFF_DRV_FEAT_SEL  = 9'h024;
    localparam offset_t OFF_QUEUE_SEL     = 9'h030;
    localparam offset_t OFF_QUEUE_NUM_MAX = 9'h034;
    localparam offset_t OFF_QUEUE_NUM     = 9'h038;
    localparam offset_t OFF_QUEUE_READY   = 9'h044;
    localparam offset_t OFF_QUEUE_NOTIFY  = 9'h050;
    localparam offset_t OFF_IRQ_STATUS    = 9'h060;
    localparam offset_t OFF_IRQ_ACK       = 9'h064;
    localparam offset_t OFF_STATUS        = 9'h070;
    localparam offset_t OFF_DESC_LO       = 9'h080;
    localparam offset_t OFF_DESC_HI       = 9'h084;
    localparam offset_t OFF_AVAIL_LO      = 9'h090;
    localparam offset_t OFF_AVAIL_HI      = 9'h094;
    localparam offset_t OFF_USED_LO       = 9'h0a0;
    localparam offset_t OFF_USED_HI       = 9'h0a4;
    localparam offset_t OFF_CONFIG_GEN    = 9'h0fc;

    // Transaction commands
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_EVENT = 2'd2
    } cmd_e;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_CAPACITY   = 2'd0;
    localparam cfg_index_t CFG_GENERATION = 2'd1;
    localparam cfg_index_t CFG_PRESENT    = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [8:0]  addr_offset;
        logic [3:0]  access_size;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        irq_pending;
        logic        notify_valid;
        logic [31:0] notify_queue;
    } rsp_t;

    // Configuration write between top level and core
    typedef struct packed {
        logic       en;
        cfg_index_t index;
        logic [63:0] data;
    } cfg_wr_t;

endpackage

### rtl/virtio_mmio_block_register_file.sv
// virtio_mmio_block_register_file: top level with input and result registers
// around the register core. Depends on vmblk_pkg and vmblk_core.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------
//   in      | in_valid / in_stall  | in_data  (vmblk_pkg::req_t)
//   out     | out_valid / out_stall| out_data (vmblk_pkg::rsp_t)
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; a transaction
// accepted into the input register is decoded from there and moves into the
// result register when that register has room, where its result is offered.
// rst_n clears all device state and configuration registers asynchronously.
// A stalled result holds its register; the input register keeps accepting
// until it too is full. cfg_ready is always high.

module virtio_mmio_block_register_file
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  vmblk_pkg::req_t         in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output vmblk_pkg::rsp_t         out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  vmblk_pkg::cfg_index_t   cfg_index,
    input  logic [63:0]             cfg_data
);

    vmblk_pkg::req_t    req_reg;
    logic               req_valid_reg;
    vmblk_pkg::rsp_t    rsp_reg;
    logic               rsp_valid_reg;
    vmblk_pkg::rsp_t    rsp;
    vmblk_pkg::cfg_wr_t cfg_wr;
    logic               advance;

    // Move the held transaction into the result register when it has room
    assign advance  = req_valid_reg && (!rsp_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.en    = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    vmblk_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .req    (req_reg),
        .cfg_wr (cfg_wr),
        .rsp    (rsp)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            req_valid_reg <= 1'b1;
        else if (advance)
            req_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            req_reg <= in_data;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= 1'b1;
        else if (!out_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= rsp;
    end

    assign out_valid = rsp_valid_reg;
    assign out_data  = rsp_reg;

endmodule

### rtl/vmblk_cfg_rd.sv
// vmblk_cfg_rd: device config window decode and little-endian byte read
// (capacity at byte 0, block size at byte 20). Depends on vmblk_pkg.

module vmblk_cfg_rd
(
    input  logic [8:0]  addr_offset,
    input  logic [3:0]  access_size,
    input  logic [63:0] capacity,
    input  logic        present,
    output logic        in_window,
    output logic [63:0] data
);

    // One byte of the config image at window index idx
    function automatic logic [7:0] cfg_byte(input logic [9:0] idx, input logic [63:0] cap);
        logic [31:0] sb;
        logic [9:0]  d;
        sb = 32'(vmblk_pkg::SECTOR_BYTES);
        d  = idx - 10'(vmblk_pkg::BLKSIZE_AT);
        if (idx < 10'd8)
            return cap[8*idx[2:0] +: 8];
        else if (idx >= 10'(vmblk_pkg::BLKSIZE_AT) && idx < 10'(vmblk_pkg::BLKSIZE_AT + 4))
            return sb[8*d[1:0] +: 8];
        return 8'd0;
    endfunction

    logic [9:0]  off_ext;
    logic [9:0]  rel;
    logic [9:0]  last;
    logic        size_ok;
    logic [63:0] bytes;

    assign off_ext   = {1'b0, addr_offset};
    assign in_window = (off_ext >= 10'(vmblk_pkg::CFG_BASE))
                    && (off_ext < 10'(vmblk_pkg::CFG_BASE + vmblk_pkg::CFG_SPACE_BYTES));
    assign rel       = off_ext - 10'(vmblk_pkg::CFG_BASE);
    assign last      = rel + {6'd0, access_size};

    // Access must be 1..8 bytes, stay inside the window and find the device present
    assign size_ok = present && (access_size != 4'd0) && (access_size <= 4'd8)
                  && (last <= 10'(vmblk_pkg::CFG_SPACE_BYTES));

    // Byte lanes, each independent
    for (genvar k = 0; k < 8; k++) begin : g_lane
        assign bytes[8*k +: 8] = (4'(k) < access_size) ? cfg_byte(rel + 10'(k), capacity)
                                                       : 8'd0;
    end

    assign data = size_ok ? bytes : 64'd0;

endmodule

### rtl/vmblk_core.sv
// vmblk_core: device state, register decode and the registered update for one
// transaction. Depends on vmblk_pkg and vmblk_cfg_rd.

module vmblk_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  vmblk_pkg::req_t    req,
    input  vmblk_pkg::cfg_wr_t cfg_wr,
    output vmblk_pkg::rsp_t    rsp
);

    // Configuration registers
    logic [63:0] capacity_reg;
    logic [31:0] generation_reg;
    logic        present_reg;

    // Device state
    logic [31:0] dev_feat_sel_reg, dev_feat_sel_next;
    logic [31:0] drv_feat_sel_reg, drv_feat_sel_next;
    logic [63:0] drv_features_reg, drv_features_next;
    logic [31:0] queue_sel_reg,    queue_sel_next;
    logic [15:0] queue_size_reg,   queue_size_next;
    logic        queue_ready_reg,  queue_ready_next;
    logic [63:0] desc_base_reg,    desc_base_next;
    logic [63:0] avail_base_reg,   avail_base_next;
    logic [63:0] used_base_reg,    used_base_next;
    logic [31:0] irq_status_reg,   irq_status_next;
    logic [31:0] status_reg,       status_next;

    logic        in_window;
    logic [63:0] cfg_data;
    logic        is_word;
    logic        q0;
    logic [63:0] feats;
    logic [31:0] reg_word;
    logic [31:0] v;
    logic        do_write;
    logic        nfy_valid;
    logic [31:0] nfy_queue;

    vmblk_cfg_rd u_cfg_rd
    (
        .addr_offset (req.addr_offset),
        .access_size (req.access_size),
        .capacity    (capacity_reg),
        .present     (present_reg),
        .in_window   (in_window),
        .data        (cfg_data)
    );

    assign is_word  = req.access_size == vmblk_pkg::WORD_BYTES;
    assign q0       = queue_sel_reg == 32'd0;
    assign feats    = present_reg ? vmblk_pkg::FEAT_ALL : 64'd0;
    assign v        = req.write_data;
    assign do_write = fire && (req.cmd == vmblk_pkg::CMD_WRITE) && !in_window && is_word;

    // Register read decode
    always_comb
    begin
        reg_word = 32'd0;
        unique case (req.addr_offset)
            vmblk_pkg::OFF_MAGIC:      reg_word = vmblk_pkg::MAGIC_WORD;
            vmblk_pkg::OFF_VERSION:    reg_word = vmblk_pkg::VERSION_WORD;
            vmblk_pkg::OFF_DEVICE_ID:  reg_word = present_reg ? vmblk_pkg::BLOCK_ID : 32'd0;
            vmblk_pkg::OFF_VENDOR_ID:  reg_word = vmblk_pkg::VENDOR_WORD;
            vmblk_pkg::OFF_DEV_FEAT:
            begin
                if (dev_feat_sel_reg == 32'd0)
                    reg_word = feats[31:0];
                else if (dev_feat_sel_reg == 32'd1)
                    reg_word = feats[63:32];
            end
            vmblk_pkg::OFF_QUEUE_NUM_MAX:
                reg_word = (present_reg && q0) ? 32'(vmblk_pkg::QUEUE_LIMIT) : 32'd0;
            vmblk_pkg::OFF_IRQ_STATUS: reg_word = irq_status_reg;
            vmblk_pkg::OFF_STATUS:     reg_word = status_reg;
            vmblk_pkg::OFF_CONFIG_GEN: reg_word = generation_reg;
            vmblk_pkg::OFF_QUEUE_SEL:  reg_word = queue_sel_reg;
            vmblk_pkg::OFF_QUEUE_NUM:  reg_word = q0 ? {16'd0, queue_size_reg} : 32'd0;
            vmblk_pkg::OFF_QUEUE_READY: reg_word = q0 ? {31'd0, queue_ready_reg} : 32'd0;
            vmblk_pkg::OFF_DESC_LO:    reg_word = q0 ? desc_base_reg[31:0] : 32'd0;
            vmblk_pkg::OFF_DESC_HI:    reg_word = q0 ? desc_base_reg[63:32] : 32'd0;
            vmblk_pkg::OFF_AVAIL_LO:   reg_word = q0 ? avail_base_reg[31:0] : 32'd0;
            vmblk_pkg::OFF_AVAIL_HI:   reg_word = q0 ? avail_base_reg[63:32] : 32'd0;
            vmblk_pkg::OFF_USED_LO:    reg_word = q0 ? used_base_reg[31:0] : 32'd0;
            vmblk_pkg::OFF_USED_HI:    reg_word = q0 ? used_base_reg[63:32] : 32'd0;
            default:                   reg_word = 32'd0;
        endcase
    end

    // Next state for writes and completion events
    always_comb
    begin
        dev_feat_sel_next = dev_feat_sel_reg;
        drv_feat_sel_next = drv_feat_sel_reg;
        drv_features_next = drv_features_reg;
        queue_sel_next    = queue_sel_reg;
        queue_size_next   = queue_size_reg;
        queue_ready_next  = queue_ready_reg;
        desc_base_next    = desc_base_reg;
        avail_base_next   = avail_base_reg;
        used_base_next    = used_base_reg;
        irq_status_next   = irq_status_reg;
        status_next       = status_reg;
        nfy_valid         = 1'b0;
        nfy_queue         = 32'd0;

        if (do_write)
        begin
            unique case (req.addr_offset)
                vmblk_pkg::OFF_DEV_FEAT_SEL: dev_feat_sel_next = v;
                vmblk_pkg::OFF_DRV_FEAT_SEL: drv_feat_sel_next = v;
                vmblk_pkg::OFF_DRV_FEAT:
                begin
                    if (drv_feat_sel_reg != 32'd0)
                        drv_features_next[63:32] = v;
                    else
                        drv_features_next[31:0] = v;
                end
                vmblk_pkg::OFF_IRQ_ACK:      irq_status_next = irq_status_reg & ~v;
                vmblk_pkg::OFF_STATUS:
                begin
                    // writing zero resets the whole device state
                    if (v == 32'd0)
                    begin
                        dev_feat_sel_next = 32'd0;
                        drv_feat_sel_next = 32'd0;
                        drv_features_next = 64'd0;
                        queue_sel_next    = 32'd0;
                        queue_size_next   = 16'd0;
                        queue_ready_next  = 1'b0;
                        desc_base_next    = 64'd0;
                        avail_base_next   = 64'd0;
                        used_base_next    = 64'd0;
                        irq_status_next   = 32'd0;
                        status_next       = 32'd0;
                    end
                    else
                        status_next = v;
                end
                vmblk_pkg::OFF_QUEUE_SEL:    queue_sel_next = v;
                vmblk_pkg::OFF_QUEUE_NOTIFY:
                begin
                    nfy_valid = 1'b1;
                    nfy_queue = v;
                end
                default:
                begin
                    // queue setup only applies to queue 0
                    if (q0)
                    begin
                        unique case (req.addr_offset)
                            vmblk_pkg::OFF_QUEUE_NUM:
                                queue_size_next = (v > 32'(vmblk_pkg::QUEUE_LIMIT))
                                                ? 16'(vmblk_pkg::QUEUE_LIMIT) : v[15:0];
                            vmblk_pkg::OFF_QUEUE_READY: queue_ready_next = v != 32'd0;
                            vmblk_pkg::OFF_DESC_LO:     desc_base_next[31:0]   = v;
                            vmblk_pkg::OFF_DESC_HI:     desc_base_next[63:32]  = v;
                            vmblk_pkg::OFF_AVAIL_LO:    avail_base_next[31:0]  = v;
                            vmblk_pkg::OFF_AVAIL_HI:    avail_base_next[63:32] = v;
                            vmblk_pkg::OFF_USED_LO:     used_base_next[31:0]   = v;
                            vmblk_pkg::OFF_USED_HI:     used_base_next[63:32]  = v;
                            default:                    ;
                        endcase
                    end
                end
            endcase
        end
        else if (fire && (req.cmd == vmblk_pkg::CMD_EVENT))
            irq_status_next = irq_status_reg | 32'd1;
    end

    // Result of the transaction
    always_comb
    begin
        rsp.read_data = 64'd0;
        if (req.cmd == vmblk_pkg::CMD_READ)
        begin
            if (in_window)
                rsp.read_data = cfg_data;
            else if (is_word)
                rsp.read_data = {32'd0, reg_word};
        end
        rsp.irq_pending  = irq_status_next != 32'd0;
        rsp.notify_valid = nfy_valid;
        rsp.notify_queue = nfy_queue;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= 64'd0;
            generation_reg <= 32'd0;
            present_reg    <= 1'b0;
        end
        else if (cfg_wr.en)
        begin
            unique case (cfg_wr.index)
                vmblk_pkg::CFG_CAPACITY:   capacity_reg   <= cfg_wr.data;
                vmblk_pkg::CFG_GENERATION: generation_reg <= cfg_wr.data[31:0];
                vmblk_pkg::CFG_PRESENT:    present_reg    <= cfg_wr.data[0];
                default:                   ;
            endcase
        end
    end

    // Device state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_feat_sel_reg <= 32'd0;
            drv_feat_sel_reg <= 32'd0;
            drv_features_reg <= 64'd0;
            queue_sel_reg    <= 32'd0;
            queue_size_reg   <= 16'd0;
            queue_ready_reg  <= 1'b0;
            desc_base_reg    <= 64'd0;
            avail_base_reg   <= 64'd0;
            used_base_reg    <= 64'd0;
            irq_status_reg   <= 32'd0;
            status_reg       <= 32'd0;
        end
        else if (fire)
        begin
            dev_feat_sel_reg <= dev_feat_sel_next;
            drv_feat_sel_reg <= drv_feat_sel_next;
            drv_features_reg <= drv_features_next;
            queue_sel_reg    <= queue_sel_next;
            queue_size_reg   <= queue_size_next;
            queue_ready_reg  <= queue_ready_next;
            desc_base_reg    <= desc_base_next;
            avail_base_reg   <= avail_base_next;
            used_base_reg    <= used_base_next;
            irq_status_reg   <= irq_status_next;
            status_reg       <= status_next;
        end
    end

endmodule
